// File: hdl/sync_frame_receiver_crc16_defines.svh
// Assertion macros shared by the receiver RTL.
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS

`define SFR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

`define SFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`else

`define SFR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define SFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int HDR_BYTES       = 6;
    localparam int HDR_IDX_W       = 3;
    localparam int PIDX_W          = 7;
    localparam int TDATA_W         = 96;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [7:0]  SYNC_A      = 8'hA5;
    localparam logic [7:0]  SYNC_B      = 8'h5A;
    localparam logic [7:0]  HDR_VERSION = 8'h01;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC0   = 3'd0,
        PH_SYNC1   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC0    = 3'd4,
        PH_CRC1    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_GOOD      = 2'd0,
        EV_MALFORMED = 2'd1,
        EV_CRC_ERR   = 2'd2,
        EV_TIMEOUT   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_READ = 2'd1,
        CTL_LOAD = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

// File: hdl/sfr_crc16_serial.sv
module sfr_crc16_serial import sfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_cmd_t    cmd,
    output logic        busy,
    output logic [15:0] crc
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        busy_reg, busy_next;
    logic        feedback;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
        end
        shift_reg <= shift_next;
    end

    always_comb begin
        crc_next     = crc_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        feedback     = crc_reg[15] ^ shift_reg[7];
        if (busy_reg) begin
            crc_next     = {crc_reg[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
            shift_next   = {shift_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end else if (cmd.init) begin
            crc_next = CRC_INIT;
        end else if (cmd.start) begin
            shift_next   = cmd.data;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

// File: hdl/sfr_payload_ram.sv
module sfr_payload_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sync_frame_receiver_crc16.sv
// Frame receiver for A5 5A framed packets checked by CRC-16/CCITT-FALSE. Each input item is a
// received byte or a one millisecond tick. A header or payload byte runs through a bit-serial
// CRC unit, one bit per clock, so s_tready stays low while that unit is busy with it. It is also
// low after any byte or tick that yields a result, until that result is handed on. A good
// frame is delivered as one item per payload byte, each via a read state and a load state, paced by
// the registered read of the payload memory; errors and timeouts give a single item with tlast
// set. The timeout register lies at byte address 0 of the APB port.
`include "sync_frame_receiver_crc16_defines.svh"

module sync_frame_receiver_crc16 import sfr_pkg::*; #(
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    input  logic               s_tuser,   // opcode
    output logic               m_tvalid,
    input  logic               m_tready,
    // frame_type, sequence_res, frame_length, payload_byte, byte_index, malformed_count,
    // crc_error_count, timeout_count, zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // event_kind
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

    phase_t               phase_reg, phase_next;
    logic [7:0]           hdr_reg [HDR_BYTES];
    logic [HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic [PIDX_W-1:0]    pay_idx_reg, pay_idx_next;
    logic [PIDX_W-1:0]    decl_len_reg, decl_len_next;
    logic [7:0]           rx_crc_lo_reg, rx_crc_lo_next;
    logic [15:0]          idle_reg, idle_next;
    logic [15:0]          mal_cnt_reg, mal_cnt_next;
    logic [15:0]          crc_cnt_reg, crc_cnt_next;
    logic [15:0]          tmo_cnt_reg, tmo_cnt_next;
    logic [15:0]          timeout_reg;

    ctl_state_t           ctl_reg, ctl_next;
    event_t               kind_reg, kind_next;
    logic                 multi_reg, multi_next;
    logic [PIDX_W-1:0]    emit_idx_reg, emit_idx_next;
    logic [PIDX_W-1:0]    emit_len_reg, emit_len_next;

    logic                 m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [1:0]           m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    logic                 accept;
    logic                 hdr_we;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    crc_cmd_t             crc_cmd;
    logic                 crc_busy;
    logic [15:0]          crc_value;
    logic                 emit_single;
    logic                 emit_multi;
    event_t               emit_kind;
    phase_t               resync_phase;
    logic [15:0]          idle_inc;
    logic [15:0]          len16;
    logic [PIDX_W-1:0]    pay_inc;
    logic                 out_free;
    logic                 is_good;
    logic                 res_last;
    logic [7:0]           f_type;
    logic [15:0]          f_seq;
    logic [6:0]           f_len;
    logic [7:0]           f_byte;
    logic [5:0]           f_idx;
    logic                 cfg_we;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (ctl_reg == CTL_IDLE) && !crc_busy;

    sfr_crc16_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (crc_cmd),
        .busy    (crc_busy),
        .crc     (crc_value)
    );

    sfr_payload_ram #(
        .DEPTH (MAX_PAYLOAD_BYTES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pay_idx_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (emit_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, timeout_reg} : 32'h0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC0;
            hdr_idx_reg   <= '0;
            pay_idx_reg   <= '0;
            decl_len_reg  <= '0;
            rx_crc_lo_reg <= '0;
            idle_reg      <= '0;
            mal_cnt_reg   <= '0;
            crc_cnt_reg   <= '0;
            tmo_cnt_reg   <= '0;
            timeout_reg   <= TIMEOUT_RST;
            ctl_reg       <= CTL_IDLE;
            kind_reg      <= EV_GOOD;
            multi_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            emit_len_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            pay_idx_reg   <= pay_idx_next;
            decl_len_reg  <= decl_len_next;
            rx_crc_lo_reg <= rx_crc_lo_next;
            idle_reg      <= idle_next;
            mal_cnt_reg   <= mal_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            if (cfg_we && paddr[2] == 1'b0) begin
                timeout_reg <= pwdata[15:0];
            end
            ctl_reg       <= ctl_next;
            kind_reg      <= kind_next;
            multi_reg     <= multi_next;
            emit_idx_reg  <= emit_idx_next;
            emit_len_reg  <= emit_len_next;
            m_valid_reg   <= m_valid_next;
        end
        if (hdr_we) begin
            hdr_reg[hdr_idx_reg] <= s_tdata;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        pay_idx_next   = pay_idx_reg;
        decl_len_next  = decl_len_reg;
        rx_crc_lo_next = rx_crc_lo_reg;
        idle_next      = idle_reg;
        mal_cnt_next   = mal_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        tmo_cnt_next   = tmo_cnt_reg;
        hdr_we         = 1'b0;
        ram_we         = 1'b0;
        crc_cmd        = '0;
        crc_cmd.data   = s_tdata;
        emit_single    = 1'b0;
        emit_multi     = 1'b0;
        emit_kind      = EV_GOOD;
        resync_phase   = (s_tdata == SYNC_A) ? PH_SYNC1 : PH_SYNC0;
        idle_inc       = (idle_reg == COUNT_MAX) ? idle_reg : idle_reg + 16'd1;
        len16          = {s_tdata, hdr_reg[4]};
        pay_inc        = pay_idx_reg + PIDX_W'(1);
        if (accept) begin
            if (s_tuser == OP_TICK) begin
                idle_next = idle_inc;
                if (phase_reg != PH_SYNC0 && idle_inc > timeout_reg) begin
                    tmo_cnt_next  = tmo_cnt_reg + 16'd1;
                    phase_next    = PH_SYNC0;
                    hdr_idx_next  = '0;
                    pay_idx_next  = '0;
                    decl_len_next = '0;
                    emit_single   = 1'b1;
                    emit_kind     = EV_TIMEOUT;
                end
            end else begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_SYNC1: begin
                        if (s_tdata == SYNC_B) begin
                            phase_next   = PH_HEADER;
                            hdr_idx_next = '0;
                            crc_cmd.init = 1'b1;
                        end else begin
                            phase_next    = resync_phase;
                            hdr_idx_next  = '0;
                            pay_idx_next  = '0;
                            decl_len_next = '0;
                        end
                    end
                    PH_HEADER: begin
                        hdr_we        = 1'b1;
                        hdr_idx_next  = hdr_idx_reg + HDR_IDX_W'(1);
                        crc_cmd.start = 1'b1;
                        if (hdr_idx_reg == HDR_IDX_W'(HDR_BYTES - 1)) begin
                            pay_idx_next  = '0;
                            decl_len_next = len16[PIDX_W-1:0];
                            if (hdr_reg[0] != HDR_VERSION
                                    || len16 > 16'(MAX_PAYLOAD_BYTES)) begin
                                mal_cnt_next  = mal_cnt_reg + 16'd1;
                                phase_next    = resync_phase;
                                hdr_idx_next  = '0;
                                decl_len_next = '0;
                                emit_single   = 1'b1;
                                emit_kind     = EV_MALFORMED;
                            end else begin
                                phase_next = (len16 == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        ram_we        = pay_idx_reg < PIDX_W'(MAX_PAYLOAD_BYTES);
                        pay_idx_next  = pay_inc;
                        crc_cmd.start = 1'b1;
                        if (pay_inc >= decl_len_reg) begin
                            phase_next = PH_CRC0;
                        end
                    end
                    PH_CRC0: begin
                        rx_crc_lo_next = s_tdata;
                        phase_next     = PH_CRC1;
                    end
                    PH_CRC1: begin
                        if (crc_value == {s_tdata, rx_crc_lo_reg}) begin
                            if (decl_len_reg == '0) begin
                                emit_single = 1'b1;
                            end else begin
                                emit_multi = 1'b1;
                            end
                            emit_kind = EV_GOOD;
                        end else begin
                            crc_cnt_next = crc_cnt_reg + 16'd1;
                            emit_single  = 1'b1;
                            emit_kind    = EV_CRC_ERR;
                        end
                        phase_next    = resync_phase;
                        hdr_idx_next  = '0;
                        pay_idx_next  = '0;
                        decl_len_next = '0;
                    end
                    default: begin
                        phase_next = resync_phase;
                    end
                endcase
            end
        end
    end

    always_comb begin
        ctl_next      = ctl_reg;
        kind_next     = kind_reg;
        multi_next    = multi_reg;
        emit_idx_next = emit_idx_reg;
        emit_len_next = emit_len_reg;
        out_free      = !m_valid_reg || m_tready;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        is_good       = (kind_reg == EV_GOOD);
        res_last      = multi_reg ? (emit_idx_reg + PIDX_W'(1) == emit_len_reg) : 1'b1;
        f_type        = is_good ? hdr_reg[1] : 8'h00;
        f_seq         = is_good ? {hdr_reg[3], hdr_reg[2]} : 16'h0000;
        f_len         = multi_reg ? emit_len_reg : 7'd0;
        f_byte        = multi_reg ? ram_rdata : 8'h00;
        f_idx         = multi_reg ? emit_idx_reg[5:0] : 6'd0;
        unique case (ctl_reg)
            CTL_IDLE: begin
                emit_idx_next = '0;
                if (emit_single) begin
                    kind_next  = emit_kind;
                    multi_next = 1'b0;
                    ctl_next   = CTL_LOAD;
                end else if (emit_multi) begin
                    kind_next     = EV_GOOD;
                    multi_next    = 1'b1;
                    emit_len_next = decl_len_reg;
                    ctl_next      = CTL_READ;
                end
            end
            CTL_READ: begin
                ctl_next = CTL_LOAD;
            end
            CTL_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = kind_reg;
                    m_last_next  = res_last;
                    m_data_next  = {3'b000, tmo_cnt_reg, crc_cnt_reg, mal_cnt_reg,
                                    f_idx, f_byte, f_len, f_seq, f_type};
                    if (res_last) begin
                        ctl_next = CTL_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + PIDX_W'(1);
                        ctl_next      = CTL_READ;
                    end
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `SFR_ASSERT_NEXT(a_crc_runs, aclk, aresetn, crc_cmd.start, crc_busy)
    `SFR_ASSERT_IMPLIES(a_emit_in_range, aclk, aresetn, (ctl_reg != CTL_IDLE && multi_reg), (emit_idx_reg < emit_len_reg))
    `SFR_ASSERT_IMPLIES(a_payload_open, aclk, aresetn, (phase_reg == PH_PAYLOAD), (pay_idx_reg < decl_len_reg))

endmodule
